// ===== sv/lcdrw_pkg.sv =====
`timescale 1ns / 1ps
package lcdrw_pkg;

  localparam logic [7:0] X_BASE_Q0   = 8'h80;
  localparam logic [7:0] X_BASE_Q1   = 8'h90;
  localparam logic [7:0] X_BASE_Q2   = 8'h88;
  localparam logic [7:0] X_BASE_Q3   = 8'h98;
  localparam logic [7:0] Y_BASE      = 8'h80;
  localparam logic [7:0] Y_WRAP_MAX  = 8'h9F;
  localparam logic [7:0] Y_HALF_MAX  = 8'h8F;
  localparam logic [7:0] X_WRAP_STEP = 8'd8;
  localparam logic [7:0] X_HALF_STEP = 8'd16;
  localparam logic [7:0] COL_MAX     = 8'd15;
  localparam logic [7:0] ROW_BAND_1  = 8'd16;
  localparam logic [7:0] ROW_BAND_2  = 8'd32;
  localparam logic [7:0] ROW_BAND_3  = 8'd48;
  localparam logic [7:0] ROW_HALF    = 8'd32;
  localparam logic [7:0] ROW_MAX     = 8'd127;
  localparam logic [7:0] INVERT_CODE = 8'd1;
  localparam logic [7:0] PAD_BYTE    = 8'h00;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_START_COLUMN = 3'd0,
    REG_START_ROW    = 3'd1,
    REG_WIDTH_BYTES  = 3'd2,
    REG_HEIGHT_ROWS  = 3'd3,
    REG_FILL_BYTE    = 3'd4,
    REG_IMAGE_SOURCE = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_Y_CMD = 2'd0,
    PH_X_CMD = 2'd1,
    PH_PAD   = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] start_column;
    logic [7:0] start_row;
    logic [7:0] width_bytes;
    logic [7:0] height_rows;
    logic [7:0] fill_byte;
    logic       image_source;
  } cfg_t;

  typedef struct packed {
    logic       hdr;
    logic       pad;
    logic [7:0] y_addr;
    logic [7:0] x_addr;
    logic [7:0] data;
    logic       done;
  } job_t;

endpackage

// ===== sv/lcdrw_front.sv =====
`timescale 1ns / 1ps
module lcdrw_front import lcdrw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       clr_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0] x_q, x_d, y_q, y_d, row_q, row_d, col_q, col_d;
  logic [7:0] xs_col, xs, v_sub, ys, xc, yc, y_inc, w_eff, h_eff, col_inc, h_m1;
  logic       start, hdr, row_end, rect_end, accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    xs_col = (cfg_i.start_column > COL_MAX) ? 8'd0 : {1'b0, cfg_i.start_column[7:1]};
    if (cfg_i.start_row < ROW_BAND_1) begin
      xs = xs_col + X_BASE_Q0;
    end else if (cfg_i.start_row < ROW_BAND_2) begin
      xs = xs_col + X_BASE_Q1;
    end else if (cfg_i.start_row < ROW_BAND_3) begin
      xs = xs_col + X_BASE_Q2;
    end else begin
      xs = xs_col + X_BASE_Q3;
    end
    v_sub = (cfg_i.start_row > ROW_BAND_2 - 8'd1) ? cfg_i.start_row - ROW_HALF
                                                  : cfg_i.start_row;
    ys = ((v_sub > ROW_MAX) ? 8'd0 : v_sub) + Y_BASE;

    start = (row_q == 8'd0) && (col_q == 8'd0);
    hdr   = (col_q == 8'd0);
    xc    = start ? xs : x_q;
    yc    = start ? ys : y_q;
    y_inc = yc + 8'd1;

    x_d = xc;
    y_d = yc;
    if (hdr) begin
      if (y_inc > Y_WRAP_MAX) begin
        x_d = xc - X_WRAP_STEP;
        y_d = Y_BASE;
      end else if (y_inc > Y_HALF_MAX && xc <= Y_HALF_MAX) begin
        x_d = xc + X_HALF_STEP;
        y_d = y_inc;
      end else begin
        y_d = y_inc;
      end
    end

    w_eff    = (cfg_i.width_bytes == 8'd0) ? 8'd1 : cfg_i.width_bytes;
    h_eff    = (cfg_i.height_rows == 8'd0) ? 8'd1 : cfg_i.height_rows;
    h_m1     = h_eff - 8'd1;
    col_inc  = col_q + 8'd1;
    row_end  = (col_inc >= w_eff) || (col_q >= w_eff);
    rect_end = row_end && (row_q >= h_m1);

    if (rect_end) begin
      row_d = 8'd0;
      col_d = 8'd0;
    end else if (row_end) begin
      row_d = row_q + 8'd1;
      col_d = 8'd0;
    end else begin
      row_d = row_q;
      col_d = col_inc;
    end

    job_o.hdr    = hdr;
    job_o.pad    = cfg_i.start_column[0];
    job_o.y_addr = yc;
    job_o.x_addr = xc;
    job_o.done   = rect_end;
    if (cfg_i.image_source) begin
      job_o.data = (cfg_i.fill_byte == INVERT_CODE) ? ~pixel_i : pixel_i;
    end else begin
      job_o.data = cfg_i.fill_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= 8'd0;
      y_q   <= 8'd0;
      row_q <= 8'd0;
      col_q <= 8'd0;
    end else if (clr_i) begin
      row_q <= 8'd0;
      col_q <= 8'd0;
    end else if (accept) begin
      x_q   <= x_d;
      y_q   <= y_d;
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== sv/lcdrw_queue.sv =====
`timescale 1ns / 1ps
module lcdrw_queue import lcdrw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  output logic head_valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t                mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !head_valid_o))
    else $error("pop from empty queue");

endmodule

// ===== sv/lcdrw_back.sv =====
`timescale 1ns / 1ps
module lcdrw_back import lcdrw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_data_o,
  output logic [7:0] bus_byte_o,
  output logic       last_o,
  output logic       rect_done_o
);

  phase_e     phase_q, phase_d, phase_eff;
  logic       load;
  logic       valid_q;
  logic       is_data_q, last_q, done_q;
  logic [7:0] byte_q;
  logic       beat_is_data, beat_last, beat_done;
  logic [7:0] beat_byte;

  assign load      = head_valid_i && (!valid_q || out_ready_i);
  assign phase_eff = (phase_q == PH_Y_CMD && !head_i.hdr) ? PH_DATA : phase_q;
  assign pop_o     = load && (phase_eff == PH_DATA);

  always_comb begin
    phase_d = phase_q;
    if (load) begin
      case (phase_eff)
        PH_Y_CMD: phase_d = PH_X_CMD;
        PH_X_CMD: phase_d = head_i.pad ? PH_PAD : PH_DATA;
        PH_PAD:   phase_d = PH_DATA;
        PH_DATA:  phase_d = PH_Y_CMD;
        default:  phase_d = PH_Y_CMD;
      endcase
    end
  end

  always_comb begin
    beat_is_data = 1'b1;
    beat_byte    = head_i.data;
    beat_last    = 1'b0;
    beat_done    = 1'b0;
    case (phase_eff)
      PH_Y_CMD: begin
        beat_is_data = 1'b0;
        beat_byte    = head_i.y_addr;
      end
      PH_X_CMD: begin
        beat_is_data = 1'b0;
        beat_byte    = head_i.x_addr;
      end
      PH_PAD: begin
        beat_byte = PAD_BYTE;
      end
      PH_DATA: begin
        beat_last = 1'b1;
        beat_done = head_i.done;
      end
      default: begin
        beat_byte = head_i.data;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_Y_CMD;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_data_q <= beat_is_data;
      byte_q    <= beat_byte;
      last_q    <= beat_last;
      done_q    <= beat_done;
    end
  end

  assign out_valid_o = valid_q;
  assign is_data_o   = is_data_q;
  assign bus_byte_o  = byte_q;
  assign last_o      = last_q;
  assign rect_done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q && last_q) |-> is_data_q)
    else $error("last transfer is not a data byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q && done_q) |-> last_q)
    else $error("rectangle end without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (load && phase_eff == PH_Y_CMD) |=> (phase_q == PH_X_CMD))
    else $error("Y command not followed by X command");

endmodule

// ===== sv/lcd_rect_write_sequencer.sv =====
`timescale 1ns / 1ps
// Rectangle writer for a 128x64 graphic LCD in split-screen graphic mode. Each
// accepted image byte yields one output transfer mid-row and up to four at a
// row start (Y address, X address, optional pad byte, data byte); the last one
// carries tlast, and tdata[8] flags the final data byte of the rectangle. The
// output side moves one transfer per cycle while m_axis_tready is high and the
// queue holds an item, through the single output register. A two-entry queue
// separates the input side from the output sequencer. Any write to a defined
// register restarts the rectangle with the next item.
module lcd_rect_write_sequencer import lcdrw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] bus_byte, [8] rect_done, [15:9] zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] is_data
);

  cfg_t       cfg_q;
  logic       clr;
  logic       full, push, head_valid, pop;
  job_t       push_job, head_job;
  logic [7:0] bus_byte;
  logic       rect_done;

  always_comb begin
    clr = cfg_we_i && (cfg_idx_i inside {REG_START_COLUMN, REG_START_ROW,
                                         REG_WIDTH_BYTES, REG_HEIGHT_ROWS,
                                         REG_FILL_BYTE, REG_IMAGE_SOURCE});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_column <= 8'd0;
      cfg_q.start_row    <= 8'd0;
      cfg_q.width_bytes  <= 8'd1;
      cfg_q.height_rows  <= 8'd1;
      cfg_q.fill_byte    <= 8'd0;
      cfg_q.image_source <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_COLUMN: cfg_q.start_column <= cfg_wdata_i;
        REG_START_ROW:    cfg_q.start_row    <= cfg_wdata_i;
        REG_WIDTH_BYTES:  cfg_q.width_bytes  <= cfg_wdata_i;
        REG_HEIGHT_ROWS:  cfg_q.height_rows  <= cfg_wdata_i;
        REG_FILL_BYTE:    cfg_q.fill_byte    <= cfg_wdata_i;
        REG_IMAGE_SOURCE: cfg_q.image_source <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  lcdrw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clr_i      (clr),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .pixel_i    (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  lcdrw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_job),
    .pop_i        (pop)
  );

  lcdrw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .is_data_o    (m_axis_tuser),
    .bus_byte_o   (bus_byte),
    .last_o       (m_axis_tlast),
    .rect_done_o  (rect_done)
  );

  assign m_axis_tdata = {7'd0, rect_done, bus_byte};

endmodule
